// ===== rtl/core/huffman_stuffed_bit_packer_core_assert.svh =====
// assertion macros shared by the huffman stuffed bit packer rtl
`ifndef HUFFMAN_STUFFED_BIT_PACKER_CORE_ASSERT_SVH
`define HUFFMAN_STUFFED_BIT_PACKER_CORE_ASSERT_SVH

// same-cycle implication, checked on every rising edge outside reset
`define HBP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on every rising edge outside reset
`define HBP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/hbp_pkg.sv =====
// types and codes shared by the huffman stuffed bit packer
`timescale 1ns / 1ps

package hbp_pkg;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_ENCODE = 2'd1;
  localparam logic [1:0] CMD_END = 2'd2;

  localparam logic [2:0] STUFF_RUN_RESET = 3'd5;
  localparam logic [2:0] STUFF_RUN_MIN = 3'd4;
  localparam logic [2:0] HEADER_BITS = 3'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_SEND,
    S_FLUSH,
    S_ONE
  } state_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic [2:0] pad_bits;
    logic       bad_symbol;
    logic       last;
  } res_t;

endpackage

// ===== rtl/core/hbp_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps

module hbp_ram #(
  parameter int WIDTH = 38,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/huffman_stuffed_bit_packer_core.sv =====
// Huffman code packer with bit stuffing. A table write (cmd 0) gives no
// beat. An encode (cmd 1) does the table lookup in the code ram (S_LOOK),
// then sends each bit through the shared stuff and pack step (S_SEND; code
// length plus stuffed bits, at most 40), then releases the final byte
// (S_FLUSH), and takes longer while the result side stalls. An end of
// stream (cmd 2) gives one beat (S_ONE). The block holds in_stall high
// while an item is at work. Each completed byte is one result beat, the
// last beat of an item carries out_last. The table comes out of reset
// empty, no clearing pass is needed.
`timescale 1ns / 1ps

`include "huffman_stuffed_bit_packer_core_assert.svh"

module huffman_stuffed_bit_packer_core
  import hbp_pkg::*;
#(
  parameter int SYMBOL_COUNT = 256,
  parameter int CODE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_stuff_run,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [7:0]  in_symbol,
  input  logic [31:0] in_code_value,
  input  logic [5:0]  in_code_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_byte_valid,
  output logic [2:0]  out_pad_bits,
  output logic        out_bad_symbol,
  output logic        out_last
);

  localparam int CW = (CODE_WIDTH < 32) ? CODE_WIDTH : 32;
  localparam int AW = $clog2(SYMBOL_COUNT);
  localparam int CIW = $clog2(CW);
  localparam int RW = CW + 6;

  state_t state_r, state_nxt;

  logic [2:0]    stuff_run_r;
  logic [SYMBOL_COUNT-1:0] present_r, present_nxt;
  logic          look_ok_r, look_ok_nxt;
  logic [CW-1:0] code_r, code_nxt;
  logic [5:0]    cnt_r, cnt_nxt;
  logic          stuff_pend_r, stuff_pend_nxt;
  logic          stuff_bit_r, stuff_bit_nxt;
  logic [6:0]    pbits_r, pbits_nxt;
  logic [2:0]    pcnt_r, pcnt_nxt;
  logic [2:0]    ones_r, ones_nxt;
  logic [2:0]    zeros_r, zeros_nxt;
  logic          held_valid_r, held_valid_nxt;
  logic [7:0]    held_byte_r, held_byte_nxt;
  res_t          one_r, one_nxt;
  res_t          out_r, out_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic          accept;
  logic          out_free;
  logic          in_range;
  logic [AW-1:0] sym_idx;
  logic [5:0]    wr_len;
  logic          ram_we;
  logic [RW-1:0] ram_rdata;
  logic [5:0]    look_len;
  logic [2:0]    run;
  logic [CIW-1:0] bit_idx;
  logic          step_bit;
  logic          step_done;

  assign accept = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign in_range = ({1'b0, in_symbol} < 9'(SYMBOL_COUNT));
  assign sym_idx = in_symbol[AW-1:0];
  assign wr_len = (in_code_length > 6'(CW)) ? 6'(CW) : in_code_length;
  assign ram_we = accept && (in_cmd == CMD_WRITE) && in_range;
  assign look_len = look_ok_r ? ram_rdata[RW-1 -: 6] : 6'd0;
  assign run = (stuff_run_r < STUFF_RUN_MIN) ? STUFF_RUN_MIN : stuff_run_r;
  assign bit_idx = CIW'(cnt_r - 6'd1);
  assign step_bit = stuff_pend_r ? stuff_bit_r : code_r[bit_idx];
  assign step_done = !stuff_pend_nxt && (cnt_nxt == 6'd0);

  hbp_ram #(
    .WIDTH (RW),
    .DEPTH (SYMBOL_COUNT)
  ) u_code_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (sym_idx),
    .wdata ({wr_len, in_code_value[CW-1:0]}),
    .raddr (sym_idx),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && in_cmd == CMD_ENCODE) begin
          state_nxt = S_LOOK;
        end else if (accept && in_cmd == CMD_END) begin
          state_nxt = S_ONE;
        end
      end
      S_LOOK: begin
        state_nxt = (look_len == 6'd0) ? S_ONE : S_SEND;
      end
      S_SEND: begin
        if (out_free && step_done) begin
          state_nxt = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (!held_valid_r || out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_ONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    logic [2:0] pad;
    logic [7:0] full;
    pad = 3'd0;
    full = 8'd0;
    present_nxt = present_r;
    look_ok_nxt = look_ok_r;
    code_nxt = code_r;
    cnt_nxt = cnt_r;
    stuff_pend_nxt = stuff_pend_r;
    stuff_bit_nxt = stuff_bit_r;
    pbits_nxt = pbits_r;
    pcnt_nxt = pcnt_r;
    ones_nxt = ones_r;
    zeros_nxt = zeros_r;
    held_valid_nxt = held_valid_r;
    held_byte_nxt = held_byte_r;
    one_nxt = one_r;
    out_nxt = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_IDLE: begin
        if (ram_we) begin
          present_nxt[sym_idx] = 1'b1;
        end
        look_ok_nxt = in_range && present_r[sym_idx];
        if (accept && in_cmd == CMD_END) begin
          one_nxt = '0;
          one_nxt.last = 1'b1;
          if (pcnt_r != 3'd0) begin
            pad = 3'(4'd8 - {1'b0, pcnt_r});
            full = 8'({1'b0, pbits_r} << pad);
            one_nxt.out_byte = full;
            one_nxt.byte_valid = 1'b1;
            one_nxt.pad_bits = pad;
          end
          pbits_nxt = 7'd0;
          pcnt_nxt = HEADER_BITS;
          ones_nxt = 3'd0;
          zeros_nxt = 3'd0;
        end
      end
      S_LOOK: begin
        one_nxt = '0;
        one_nxt.bad_symbol = 1'b1;
        one_nxt.last = 1'b1;
        code_nxt = ram_rdata[CW-1:0];
        cnt_nxt = look_len;
        stuff_pend_nxt = 1'b0;
        held_valid_nxt = 1'b0;
      end
      S_SEND: begin
        if (out_free) begin
          // pack the bit
          if (pcnt_r == 3'd7) begin
            full = {pbits_r, step_bit};
            pbits_nxt = 7'd0;
            pcnt_nxt = 3'd0;
            if (held_valid_r) begin
              out_nxt = '0;
              out_nxt.out_byte = held_byte_r;
              out_nxt.byte_valid = 1'b1;
              out_valid_nxt = 1'b1;
            end
            held_valid_nxt = 1'b1;
            held_byte_nxt = full;
          end else begin
            pbits_nxt = {pbits_r[5:0], step_bit};
            pcnt_nxt = pcnt_r + 3'd1;
          end
          // stuffed bits count toward neither run
          if (stuff_pend_r) begin
            stuff_pend_nxt = 1'b0;
          end else begin
            cnt_nxt = cnt_r - 6'd1;
            if (step_bit) begin
              zeros_nxt = 3'd0;
              if ({1'b0, ones_r} + 4'd1 >= {1'b0, run}) begin
                stuff_pend_nxt = 1'b1;
                stuff_bit_nxt = 1'b0;
                ones_nxt = 3'd0;
              end else begin
                ones_nxt = ones_r + 3'd1;
              end
            end else begin
              ones_nxt = 3'd0;
              if ({1'b0, zeros_r} + 4'd1 >= {1'b0, run}) begin
                stuff_pend_nxt = 1'b1;
                stuff_bit_nxt = 1'b1;
                zeros_nxt = 3'd0;
              end else begin
                zeros_nxt = zeros_r + 3'd1;
              end
            end
          end
        end
      end
      S_FLUSH: begin
        if (held_valid_r && out_free) begin
          out_nxt = '0;
          out_nxt.out_byte = held_byte_r;
          out_nxt.byte_valid = 1'b1;
          out_nxt.last = 1'b1;
          out_valid_nxt = 1'b1;
          held_valid_nxt = 1'b0;
        end
      end
      S_ONE: begin
        if (out_free) begin
          out_nxt = one_r;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      stuff_run_r <= STUFF_RUN_RESET;
      present_r <= '0;
      stuff_pend_r <= 1'b0;
      pbits_r <= 7'd0;
      pcnt_r <= HEADER_BITS;
      ones_r <= 3'd0;
      zeros_r <= 3'd0;
      held_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r <= 6'd0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        stuff_run_r <= cfg_stuff_run;
      end
      present_r <= present_nxt;
      stuff_pend_r <= stuff_pend_nxt;
      pbits_r <= pbits_nxt;
      pcnt_r <= pcnt_nxt;
      ones_r <= ones_nxt;
      zeros_r <= zeros_nxt;
      held_valid_r <= held_valid_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    look_ok_r <= look_ok_nxt;
    code_r <= code_nxt;
    stuff_bit_r <= stuff_bit_nxt;
    held_byte_r <= held_byte_nxt;
    one_r <= one_nxt;
    out_r <= out_nxt;
  end

  assign cfg_ready = 1'b1;
  assign in_stall = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_byte = out_r.out_byte;
  assign out_byte_valid = out_r.byte_valid;
  assign out_pad_bits = out_r.pad_bits;
  assign out_bad_symbol = out_r.bad_symbol;
  assign out_last = out_r.last;

  `HBP_ASSERT_NOW(a_empty_beat_zero, out_valid && !out_byte_valid,
    out_byte == 8'd0 && out_pad_bits == 3'd0, "beat without byte carries data")
  `HBP_ASSERT_NOW(a_bad_is_last, out_valid && out_bad_symbol,
    out_last && !out_byte_valid, "bad symbol beat is not a lone final beat")
  `HBP_ASSERT_NOW(a_pad_on_last, out_valid && out_pad_bits != 3'd0,
    out_last && out_byte_valid, "pad count outside end of stream beat")
  `HBP_ASSERT_NOW(a_send_has_work, state_r == S_SEND,
    cnt_r != 6'd0 || stuff_pend_r, "send step with no bit left")
  `HBP_ASSERT_NOW(a_one_run, 1'b1,
    ones_r == 3'd0 || zeros_r == 3'd0, "both run counters active")

endmodule
